>>> rtl/core/assert_macros.svh
// Assertion helpers used by fpr_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define FPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/fpr_pkg.sv
package fpr_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int LEN_W          = 4;
    localparam int IDX_W          = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  START_BYTE = 8'h54;
    localparam logic [7:0]  FILL_BYTE  = 8'hFF;
    localparam logic [15:0] NO_ID      = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] sender_addr;
        logic        buffer_start;
    } in_item_t;

    typedef struct packed {
        logic [15:0]      frame_source;
        logic [15:0]      frame_id;
        logic [LEN_W-1:0] frame_length;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       data_value;
        logic             last;
    } out_item_t;

    typedef logic [MAX_DATA_BYTES-1:0][7:0] payload_t;

    typedef struct packed {
        logic [15:0]      source;
        logic [15:0]      id;
        logic [LEN_W-1:0] length;
        payload_t         payload;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/core/fpr_parser.sv
module fpr_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              checksum_enable,
    input  logic              s_valid,
    output logic              s_ready,
    input  fpr_pkg::in_item_t s_item,
    input  fpr_pkg::q_status_t q_status,
    output logic              push,
    output fpr_pkg::frame_t   push_frame
);
    import fpr_pkg::*;

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_ID_HI = 3'd1;
    localparam logic [2:0] PH_ID_LO = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SUM   = 3'd5;

    logic [2:0]       phase_reg, phase_next, phase_eff;
    logic [15:0]      sender_reg, sender_next;
    logic [15:0]      id_reg, id_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [7:0]       sum_reg, sum_next;
    payload_t         payload_reg, payload_next;
    logic             accept, restart;
    logic [7:0]       b;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign b       = s_item.data_byte;
    assign restart = s_item.buffer_start || (s_item.sender_addr != sender_reg);
    assign phase_eff = restart ? PH_WAIT : phase_reg;
    assign cnt_inc = cnt_reg + LEN_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        sender_next  = sender_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        payload_next = payload_reg;
        push         = 1'b0;
        if (accept) begin
            sender_next = s_item.sender_addr;
            case (phase_eff)
                PH_WAIT: begin
                    id_next    = NO_ID;
                    len_next   = '0;
                    cnt_next   = '0;
                    sum_next   = '0;
                    phase_next = (b == START_BYTE) ? PH_ID_HI : PH_WAIT;
                end
                PH_ID_HI: begin
                    id_next    = {b, 8'h00};
                    sum_next   = b;
                    phase_next = PH_ID_LO;
                end
                PH_ID_LO: begin
                    id_next    = {id_reg[15:8], b};
                    sum_next   = sum_reg + b;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (b > 8'(MAX_DATA_BYTES)) begin
                        phase_next = PH_WAIT;
                    end else begin
                        len_next = b[LEN_W-1:0];
                        sum_next = sum_reg + b;
                        if (b != 8'd0) begin
                            phase_next = PH_DATA;
                        end else if (checksum_enable) begin
                            phase_next = PH_SUM;
                        end else begin
                            push       = 1'b1;
                            phase_next = PH_WAIT;
                        end
                    end
                end
                PH_DATA: begin
                    // count never reaches the store depth here: length is capped
                    payload_next[cnt_reg[IDX_W-1:0]] = b;
                    cnt_next = cnt_inc;
                    sum_next = sum_reg + b;
                    if (cnt_inc >= len_reg) begin
                        if (checksum_enable) begin
                            phase_next = PH_SUM;
                        end else begin
                            push       = 1'b1;
                            phase_next = PH_WAIT;
                        end
                    end
                end
                PH_SUM: begin
                    push       = (b == sum_reg);
                    phase_next = PH_WAIT;
                end
                default: begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_comb begin
        push_frame.source  = sender_next;
        push_frame.id      = id_next;
        push_frame.length  = len_next;
        push_frame.payload = payload_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT;
            sender_reg <= '0;
            id_reg     <= NO_ID;
            len_reg    <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            sender_reg <= sender_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
    end

endmodule

>>> rtl/core/fpr_queue.sv
module fpr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fpr_pkg::frame_t    push_frame,
    input  logic               pop,
    output fpr_pkg::frame_t    head,
    output fpr_pkg::q_status_t q_status
);
    import fpr_pkg::*;

    frame_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/fpr_emitter.sv
module fpr_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  fpr_pkg::frame_t    head,
    input  fpr_pkg::q_status_t q_status,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output fpr_pkg::out_item_t m_item
);
    import fpr_pkg::*;

    logic [IDX_W-1:0] k_reg, k_next;
    logic             zero_len, is_last, accept;

    assign zero_len = (head.length == '0);
    assign is_last  = zero_len || ((LEN_W'(k_reg) + LEN_W'(1)) == head.length);
    assign m_valid  = !q_status.empty;
    assign accept   = m_valid && m_ready;
    assign pop      = accept && is_last;

    always_comb begin
        m_item.frame_source = head.source;
        m_item.frame_id     = head.id;
        m_item.frame_length = head.length;
        m_item.byte_index   = k_reg;
        m_item.data_value   = zero_len ? FILL_BYTE : head.payload[k_reg];
        m_item.last         = is_last;
    end

    always_comb begin
        k_next = k_reg;
        if (accept) begin
            k_next = is_last ? '0 : k_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else begin
            k_reg <= k_next;
        end
    end

endmodule

>>> rtl/core/framed_packet_receiver.sv
// From an empty queue, a frame's first result is offered the cycle after its closing
// byte is taken. One byte in per cycle while s_ready is high, one result out per
// cycle while m_ready is high, a run per frame. A two-frame queue separates parser
// and emitter; s_ready drops only while it is full. Reset (aresetn, synchronous,
// active low): parser waits for a start byte, queue empty, checksum_enable set to 1.
module framed_packet_receiver (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  fpr_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output fpr_pkg::out_item_t m_item
);
    import fpr_pkg::*;

    logic      checksum_enable_reg;
    logic      push, pop;
    frame_t    push_frame, head;
    q_status_t q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            checksum_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            checksum_enable_reg <= cfg_wr_data;
        end
    end

    fpr_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .checksum_enable (checksum_enable_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .q_status        (q_status),
        .push            (push),
        .push_frame      (push_frame)
    );

    fpr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    fpr_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

>>> rtl/core/fpr_checker.sv
`include "assert_macros.svh"

module fpr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input fpr_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input fpr_pkg::out_item_t m_item
);
    import fpr_pkg::*;

    logic zero_len, zero_len_ok, idx_ok;

    assign zero_len    = (m_item.frame_length == '0);
    assign zero_len_ok = m_item.last && (m_item.data_value == FILL_BYTE)
                         && (m_item.byte_index == '0);
    assign idx_ok      = (LEN_W'(m_item.byte_index) < m_item.frame_length)
                         && (m_item.frame_length <= LEN_W'(MAX_DATA_BYTES));

    // input side holds a stalled item
    `FPR_ASSERT_NXT(a_s_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_item))
    // a stalled result stays put
    `FPR_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    // a run has no gaps once started
    `FPR_ASSERT_NXT(a_run_cont, aclk, aresetn, m_valid && m_ready && !m_item.last, m_valid)
    `FPR_ASSERT_IMP(a_zero_len, aclk, aresetn, m_valid && zero_len, zero_len_ok)
    `FPR_ASSERT_IMP(a_idx_range, aclk, aresetn, m_valid && !zero_len, idx_ok)

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_item      (s_item),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_item      (m_item)
);

>>> tb/fpr_frame_checker.sv
module fpr_frame_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  fpr_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  fpr_pkg::out_item_t m_item,
    output int                 error_count,
    output int                 results_due,
    output int                 results_seen
);
    import fpr_pkg::*;

    typedef enum logic [2:0] {
        SEEK_START,
        TAKE_ID_HI,
        TAKE_ID_LO,
        TAKE_LEN,
        TAKE_PAYLOAD,
        TAKE_SUM
    } parse_phase_e;

    parse_phase_e     phase;
    logic             sum_check;
    logic [15:0]      sender;
    logic [15:0]      frame_id;
    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] rx_count;
    logic [7:0]       body [MAX_DATA_BYTES];
    logic [7:0]       sum;

    out_item_t frame_results_q [$];
    int        mismatches = 0;
    int        checked    = 0;

    // A finished frame becomes one item per payload byte, or a single filler item.
    task automatic queue_frame();
        out_item_t r;
        int        k;
        r.frame_source = sender;
        r.frame_id     = frame_id;
        r.frame_length = frame_len;
        if (frame_len == 0) begin
            r.byte_index = '0;
            r.data_value = FILL_BYTE;
            r.last       = 1'b1;
            frame_results_q.push_back(r);
        end else begin
            for (k = 0; k < frame_len; k++) begin
                r.byte_index = k[IDX_W-1:0];
                r.data_value = body[k];
                r.last       = (k == frame_len - 1);
                frame_results_q.push_back(r);
            end
        end
    endtask

    task automatic parse_rx_byte(in_item_t it);
        logic [7:0] b;
        b = it.data_byte;
        if (it.buffer_start || it.sender_addr != sender) begin
            sender = it.sender_addr;
            phase  = SEEK_START;
        end
        case (phase)
            SEEK_START: begin
                frame_id  = NO_ID;
                frame_len = '0;
                rx_count  = '0;
                sum       = '0;
                if (b == START_BYTE)
                    phase = TAKE_ID_HI;
            end
            TAKE_ID_HI: begin
                frame_id = {b, 8'h00};
                sum      = b;
                phase    = TAKE_ID_LO;
            end
            TAKE_ID_LO: begin
                frame_id[7:0] = b;
                sum           = sum + b;
                phase         = TAKE_LEN;
            end
            TAKE_LEN: begin
                if (b > MAX_DATA_BYTES) begin
                    phase = SEEK_START;
                end else begin
                    frame_len = b[LEN_W-1:0];
                    sum       = sum + b;
                    if (b != 0) begin
                        phase = TAKE_PAYLOAD;
                    end else if (sum_check) begin
                        phase = TAKE_SUM;
                    end else begin
                        queue_frame();
                        phase = SEEK_START;
                    end
                end
            end
            TAKE_PAYLOAD: begin
                if (rx_count < MAX_DATA_BYTES)
                    body[rx_count[IDX_W-1:0]] = b;
                rx_count = rx_count + 1'b1;
                sum      = sum + b;
                if (rx_count >= frame_len) begin
                    if (sum_check) begin
                        phase = TAKE_SUM;
                    end else begin
                        queue_frame();
                        phase = SEEK_START;
                    end
                end
            end
            TAKE_SUM: begin
                if (b == sum)
                    queue_frame();
                phase = SEEK_START;
            end
            default: phase = SEEK_START;
        endcase
    endtask

    function automatic int field_check(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_result(out_item_t got);
        out_item_t want;
        checked++;
        if (frame_results_q.size() == 0) begin
            $error("result item with no frame pending: %h", got);
            mismatches++;
        end else begin
            want = frame_results_q.pop_front();
            mismatches += field_check("frame_source", want.frame_source, got.frame_source);
            mismatches += field_check("frame_id", want.frame_id, got.frame_id);
            mismatches += field_check("frame_length", 16'(want.frame_length),
                                      16'(got.frame_length));
            mismatches += field_check("byte_index", 16'(want.byte_index), 16'(got.byte_index));
            mismatches += field_check("data_value", 16'(want.data_value), 16'(got.data_value));
            mismatches += field_check("last", 16'(want.last), 16'(got.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase     = SEEK_START;
            sum_check = 1'b1;
            sender    = '0;
            frame_id  = NO_ID;
            frame_len = '0;
            rx_count  = '0;
            sum       = '0;
            frame_results_q.delete();
        end else begin
            if (s_valid && s_ready)
                parse_rx_byte(s_item);
            if (m_valid && m_ready)
                check_result(m_item);
            if (cfg_wr_en)
                sum_check = cfg_wr_data;
        end
        results_due  <= frame_results_q.size();
        error_count  <= mismatches;
        results_seen <= checked;
    end

endmodule

>>> tb/framed_packet_receiver_test.sv
module framed_packet_receiver_test;
    import fpr_pkg::*;

    logic      aclk;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_item_t  s_item      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_item_t m_item;

    int error_count;
    int results_due;
    int results_seen;

    bit          quiet      = 1'b0;
    bit          sum_on     = 1'b1;
    logic [15:0] link_src   = '0;
    int          bytes_sent = 0;
    int          good_frames    = 0;
    int          damaged_frames = 0;

    framed_packet_receiver DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    fpr_frame_checker frame_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .error_count  (error_count),
        .results_due  (results_due),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("framed_packet_receiver regression: fail");
        $finish;
    end

    // receiver side: random stall bursts, none once the run goes quiet
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(logic [7:0] d, logic [15:0] src, logic bs);
        in_item_t it;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        it.data_byte    = d;
        it.sender_addr  = src;
        it.buffer_start = bs;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // keep limits how many of the frame's bytes go out
    task automatic send_frame(logic [15:0] src, logic bs, logic [15:0] id,
                              logic [7:0] len_byte, payload_t body, bit bad_sum, int keep);
        logic [7:0] fb [$];
        logic [7:0] sum;
        int         k;
        fb  = '{START_BYTE, id[15:8], id[7:0], len_byte};
        sum = id[15:8] + id[7:0] + len_byte;
        if (len_byte <= MAX_DATA_BYTES) begin
            for (k = 0; k < len_byte; k++) begin
                fb.push_back(body[k]);
                sum = sum + body[k];
            end
            if (sum_on)
                fb.push_back(bad_sum ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum);
        end
        for (k = 0; k < fb.size() && k < keep; k++)
            send_byte(fb[k], src, (k == 0) ? bs : 1'b0);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_sum_enable(logic v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sum_on = v;
    endtask

    task automatic run_random(int n_bytes);
        int          target;
        int          pick;
        int          k;
        bit          force_restart;
        logic        bs;
        logic [15:0] id;
        logic [7:0]  len;
        payload_t    body;
        target        = bytes_sent + n_bytes;
        force_restart = 1'b0;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 5) == 0)
                link_src = 16'($urandom);
            bs   = force_restart || ($urandom_range(0, 4) == 0);
            force_restart = 1'b0;
            id   = 16'($urandom);
            len  = 8'($urandom_range(0, MAX_DATA_BYTES));
            body = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_frame(link_src, bs, id, len, body, 1'b0, 255);
                good_frames++;
            end else if (pick < 75 && sum_on) begin
                send_frame(link_src, bs, id, len, body, 1'b1, 255);
                damaged_frames++;
            end else if (pick < 82) begin
                send_frame(link_src, bs, id, 8'($urandom_range(MAX_DATA_BYTES + 1, 255)),
                           body, 1'b0, 255);
                damaged_frames++;
            end else if (pick < 92) begin
                // cut short; the next frame has to restart the parser
                send_frame(link_src, bs, id, len, body, 1'b0, $urandom_range(1, 3 + len));
                force_restart = 1'b1;
                damaged_frames++;
            end else begin
                // line noise, not counted as traffic
                pick = $urandom_range(1, 4);
                target += pick;
                for (k = 0; k < pick; k++)
                    send_byte(8'($urandom), link_src, 1'b0);
            end
            if (!quiet && $urandom_range(0, 39) == 0)
                wait_for_results();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // checksum on (reset value)
        send_byte(8'h00, 16'h0000, 1'b0);
        send_frame(16'hFFFF, 1'b1, 16'hFFFF, 8'd0, '0, 1'b0, 255);
        send_frame(16'hFFFF, 1'b0, 16'h0001, 8'd0, '0, 1'b1, 255);
        send_frame(16'hFFFF, 1'b0, 16'h1234, 8'(MAX_DATA_BYTES + 1), '0, 1'b0, 255);
        send_frame(16'hFFFF, 1'b0, 16'hABCD, 8'd3, '0, 1'b0, 2);
        // buffer start lands on a start byte in the middle of a broken frame
        send_frame(16'hFFFF, 1'b1, 16'h0000, 8'(MAX_DATA_BYTES),
                   {8'h54, 8'hAA, 8'h55, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00}, 1'b0, 255);
        run_random(90);
        wait_for_results();

        write_sum_enable(1'b0);
        send_frame(16'h0000, 1'b1, 16'h8001, 8'd0, '0, 1'b0, 255);
        run_random(90);
        wait_for_results();

        write_sum_enable(1'b1);
        run_random(60);
        wait_for_results();

        write_sum_enable(1'b0);
        quiet = 1'b1;
        run_random(50);
        wait_for_results();

        $display("covered %0d bytes, %0d clean and %0d damaged frames, checksum on and off",
                 bytes_sent, good_frames, damaged_frames);
        $display("%0d result items checked, %0d mismatches", results_seen, error_count);
        if (error_count == 0 && results_due == 0) begin
            $display("framed_packet_receiver regression: pass");
        end else begin
            $display("framed_packet_receiver regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/fpr_pkg.sv
rtl/core/fpr_parser.sv
rtl/core/fpr_queue.sv
rtl/core/fpr_emitter.sv
rtl/core/framed_packet_receiver.sv
rtl/core/fpr_checker.sv
tb/fpr_frame_checker.sv
tb/framed_packet_receiver_test.sv
